@@ design/phar_pkg.sv @@
package phar_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned Div3Sh = 17;
    localparam logic [Div3Sh-1:0] Div3Mul = 17'd43691;

    typedef enum logic {
        CFG_REPEAT_INTERVAL = 1'b0,
        CFG_HOLD_THRESHOLD  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             prev_level;
        logic             is_pressed;
        logic [TimeW-1:0] press_start;
        logic [TimeW-1:0] last_fire;
        logic [TimeW-1:0] release_duration;
    } t_state;

    typedef struct packed {
        logic             event_res;
        logic [TimeW-1:0] held_ms;
        logic [TimeW-1:0] released_ms;
    } t_result;

    // exact floor(x/3) for any 16-bit x
    function automatic logic [CfgW-1:0] div3(input logic [CfgW-1:0] x);
        logic [CfgW+Div3Sh-1:0] prod;
        prod = {{Div3Sh{1'b0}}, x} * {{CfgW{1'b0}}, Div3Mul};
        return prod[CfgW+Div3Sh-1:Div3Sh];
    endfunction

endpackage

@@ design/phar_core.sv @@
module phar_core
    import phar_pkg::*;
(
    input  t_state           i_state,
    input  logic [CfgW-1:0]  i_interval,
    input  logic [CfgW-1:0]  i_interval_fast,
    input  logic [CfgW-1:0]  i_threshold,
    input  logic [TimeW-1:0] i_now,
    input  logic             i_level,
    input  logic             i_ack,
    output t_state           o_state,
    output t_result          o_result
);

    logic             w_edge;
    logic [TimeW-1:0] w_held;
    logic [TimeW-1:0] w_since_fire;
    logic [CfgW-1:0]  w_rate;
    logic             w_fast;

    assign w_edge       = i_level != i_state.prev_level;
    assign w_held       = i_now - i_state.press_start;
    assign w_since_fire = i_now - i_state.last_fire;
    assign w_fast       = (i_threshold != '0) && (w_held > {{(TimeW-CfgW){1'b0}}, i_threshold});
    assign w_rate       = w_fast ? i_interval_fast : i_interval;

    always_comb begin
        t_state nxt;
        logic   ev;
        nxt            = i_state;
        ev             = 1'b0;
        nxt.prev_level = i_level;
        priority if (w_edge && i_level) begin
            nxt.press_start = i_now;
            nxt.is_pressed  = 1'b1;
            nxt.last_fire   = i_now;
            ev              = 1'b1;
        end else if (w_edge) begin
            nxt.release_duration = w_held;
            nxt.press_start      = '0;
            nxt.is_pressed       = 1'b0;
            nxt.last_fire        = '0;
        end else begin
            if (i_interval != '0 && i_state.is_pressed &&
                (w_since_fire > {{(TimeW-CfgW){1'b0}}, w_rate})) begin
                nxt.last_fire = i_now;
                ev            = 1'b1;
            end
        end
        o_result.event_res   = ev;
        o_result.held_ms     = nxt.is_pressed ? (i_now - nxt.press_start) : '0;
        o_result.released_ms = nxt.release_duration;
        // report first, then clear on acknowledge
        if (i_ack) begin
            nxt.release_duration = '0;
        end
        o_state = nxt;
    end

endmodule

@@ design/press_hold_auto_repeat.sv @@
// Auto-repeat for a polled touch sensor. Each input word is one poll: now_ms in tdata,
// touched and ack_release in tuser. Each poll yields exactly one output word carrying the
// event flag (press or repeat firing), the current held time and the last release duration.
// A poll passes an input register and then the state update into the output register; one
// poll is accepted every cycle while the output side keeps up, and the output register lets
// the next poll enter while a result waits. The user must write repeat interval and hold
// threshold via the config port only while no poll is in flight; the block does not check.
module press_hold_auto_repeat
    import phar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CfgW-1:0]      i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [TimeW-1:0]     i_s_axis_tdata,   // now_ms
    input  logic [1:0]           i_s_axis_tuser,   // touched, ack_release
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [2*TimeW-1:0]   o_m_axis_tdata,   // held_ms, released_ms
    output logic                 o_m_axis_tuser    // event_res
);

    logic [CfgW-1:0]  r_interval;
    logic [CfgW-1:0]  r_interval_fast;
    logic [CfgW-1:0]  r_threshold;

    logic             r_in_valid;
    logic [TimeW-1:0] r_in_now;
    logic             r_in_level;
    logic             r_in_ack;

    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_result          r_out;
    logic             r_out_valid;

    logic             w_advance;
    logic             w_in_take;

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval      <= '0;
            r_interval_fast <= '0;
            r_threshold     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REPEAT_INTERVAL: begin
                    r_interval      <= i_cfg_data;
                    r_interval_fast <= div3(i_cfg_data);
                end
                CFG_HOLD_THRESHOLD: begin
                    r_threshold <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_now   <= i_s_axis_tdata;
            r_in_level <= i_s_axis_tuser[0];
            r_in_ack   <= i_s_axis_tuser[1];
        end
    end

    phar_core u_core (
        .i_state         (r_state),
        .i_interval      (r_interval),
        .i_interval_fast (r_interval_fast),
        .i_threshold     (r_threshold),
        .i_now           (r_in_now),
        .i_level         (r_in_level),
        .i_ack           (r_in_ack),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.released_ms, r_out.held_ms};
    assign o_m_axis_tuser  = r_out.event_res;

`ifndef SYNTH
    a_pressed_tracks_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.is_pressed == r_state.prev_level)
        else $error("press flag out of step with touch level");

    a_released_clears_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.is_pressed |-> (r_state.press_start == '0 && r_state.last_fire == '0))
        else $error("press times not cleared while released");

    a_word_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid) |=> r_out_valid)
        else $error("processed word lost before output");
`endif

endmodule

@@ bench/tb.sv @@
module tb
    import phar_pkg::*;
();

    localparam int unsigned CycleLimit = 400000;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             touched;
        logic             ack_release;
    } t_poll;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    t_cfg_idx            cfg_idx = CFG_REPEAT_INTERVAL;
    logic [CfgW-1:0]     cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TimeW-1:0]    s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*TimeW-1:0]  m_tdata;
    logic                m_tuser;

    press_hold_auto_repeat u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    t_poll           poll_queue[$];
    t_result         predicted_reports[$];
    t_poll           next_poll;
    t_state          touch_st = '0;
    logic [CfgW-1:0] repeat_ms = '0;
    logic [CfgW-1:0] hold_ms = '0;

    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 84;
    int unsigned polls_queued = 0;
    int unsigned polls_sent = 0;
    int unsigned reports_seen = 0;
    int unsigned fired_events = 0;
    int unsigned settings_used = 1;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    logic        word_taken = 1'b0;

    initial forever #10 i_clk = ~i_clk;

    function automatic t_result advance_touch_state(input t_poll p);
        t_result          r;
        logic [TimeW-1:0] rate;
        logic             rise;
        logic             fall;
        r = '0;
        rise = p.touched && !touch_st.prev_level;
        fall = !p.touched && touch_st.prev_level;
        touch_st.prev_level = p.touched;
        if (rise) begin
            touch_st.press_start = p.now_ms;
            touch_st.is_pressed = 1'b1;
            touch_st.last_fire = p.now_ms;
            r.event_res = 1'b1;
        end else begin
            if (fall) begin
                touch_st.release_duration = p.now_ms - touch_st.press_start;
                touch_st.press_start = '0;
                touch_st.is_pressed = 1'b0;
                touch_st.last_fire = '0;
            end
            if (repeat_ms != 0 && touch_st.is_pressed) begin
                rate = {16'd0, repeat_ms};
                if (hold_ms != 0 && (p.now_ms - touch_st.press_start) > {16'd0, hold_ms})
                    rate = rate / 3;
                if ((p.now_ms - touch_st.last_fire) > rate) begin
                    touch_st.last_fire = p.now_ms;
                    r.event_res = 1'b1;
                end
            end
        end
        r.held_ms = touch_st.is_pressed ? p.now_ms - touch_st.press_start : '0;
        r.released_ms = touch_st.release_duration;
        if (p.ack_release)
            touch_st.release_duration = '0;
        return r;
    endfunction

    // sender side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (poll_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_poll = poll_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_poll.now_ms;
                s_tuser <= {next_poll.ack_release, next_poll.touched};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver side
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_poll   taken;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                taken.now_ms = s_tdata;
                taken.touched = s_tuser[0];
                taken.ack_release = s_tuser[1];
                predicted_reports.push_back(advance_touch_state(taken));
                polls_sent <= polls_sent + 1;
            end
            if (m_tvalid && m_tready) begin
                got.event_res = m_tuser;
                got.held_ms = m_tdata[TimeW-1:0];
                got.released_ms = m_tdata[2*TimeW-1:TimeW];
                reports_seen++;
                if (got.event_res)
                    fired_events++;
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    errors++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want.event_res, got.event_res);
                        errors++;
                    end
                    if (got.held_ms !== want.held_ms) begin
                        $display("%0t: held_ms expected %h actual %h",
                                 $time, want.held_ms, got.held_ms);
                        errors++;
                    end
                    if (got.released_ms !== want.released_ms) begin
                        $display("%0t: released_ms expected %h actual %h",
                                 $time, want.released_ms, got.released_ms);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_poll(input logic [TimeW-1:0] now_ms, input logic touched,
                             input logic ack_release);
        t_poll p;
        p.now_ms = now_ms;
        p.touched = touched;
        p.ack_release = ack_release;
        poll_queue.push_back(p);
        polls_queued++;
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [CfgW-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_REPEAT_INTERVAL: repeat_ms = val;
            CFG_HOLD_THRESHOLD:  hold_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CfgW-1:0] interval, input logic [CfgW-1:0] thr);
        set_register(CFG_REPEAT_INTERVAL, interval);
        set_register(CFG_HOLD_THRESHOLD, thr);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (polls_sent != polls_queued || predicted_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [TimeW-1:0] time_step(input int unsigned base);
        if ($urandom_range(15, 0) == 0)
            return $urandom();
        if ($urandom_range(7, 0) == 0)
            return '0;
        return $urandom_range(base, 0);
    endfunction

    // mostly press/hold/release runs with random timing, some noise and cut-short runs
    task automatic gen_touch_runs(input int unsigned n);
        int unsigned      made;
        int unsigned      base;
        int unsigned      k;
        logic [TimeW-1:0] t;
        made = 0;
        base = (repeat_ms == 0) ? hold_ms / 4 + 8 : repeat_ms / 2 + 2;
        t = $urandom();
        while (made < n) begin
            if ($urandom_range(99, 0) < 15) begin
                push_poll($urandom(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                made++;
            end else begin
                if ($urandom_range(3, 0) == 0)
                    t = 32'hFFFF_FFFF - $urandom_range(base * 8, 0);
                else if ($urandom_range(3, 0) == 0)
                    t = $urandom();
                repeat ($urandom_range(2, 0)) begin
                    t += time_step(base);
                    push_poll(t, 1'b0, $urandom_range(9, 0) < 3);
                    made++;
                end
                t += time_step(base);
                push_poll(t, 1'b1, $urandom_range(9, 0) < 3);
                made++;
                k = $urandom_range(25, 1);
                repeat (k) begin
                    t += time_step(base);
                    push_poll(t, 1'b1, $urandom_range(9, 0) < 3);
                    made++;
                end
                if ($urandom_range(9, 0) != 0) begin
                    t += time_step(base);
                    push_poll(t, 1'b0, $urandom_range(9, 0) < 3);
                    made++;
                    repeat ($urandom_range(2, 0)) begin
                        t += time_step(base);
                        push_poll(t, 1'b0, 1'($urandom_range(1, 0)));
                        made++;
                    end
                end
            end
        end
    endtask

    initial begin
        int ph;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: no repeats
        push_poll(32'd0, 1'b0, 1'b0);
        push_poll(32'd100, 1'b1, 1'b0);
        push_poll(32'd200, 1'b1, 1'b0);
        push_poll(32'd350, 1'b0, 1'b0);
        push_poll(32'd400, 1'b0, 1'b1);
        push_poll(32'd500, 1'b0, 1'b0);
        wait_drained();

        // strict compare, wrap, hold speed-up, max held time, ack on release
        apply_setting(16'd10, 16'd30);
        push_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
        push_poll(32'hFFFF_FFF8, 1'b1, 1'b0);
        push_poll(32'hFFFF_FFFA, 1'b1, 1'b0);
        push_poll(32'hFFFF_FFFB, 1'b1, 1'b0);
        push_poll(32'h0000_0010, 1'b1, 1'b0);
        push_poll(32'h0000_0013, 1'b1, 1'b0);
        push_poll(32'h0000_0014, 1'b1, 1'b0);
        push_poll(32'h0000_0014, 1'b1, 1'b0);
        push_poll(32'hFFFF_FFEF, 1'b1, 1'b0);
        push_poll(32'hFFFF_FFEF, 1'b0, 1'b1);
        push_poll(32'h0000_0000, 1'b1, 1'b1);
        push_poll(32'h0000_0000, 1'b0, 1'b0);
        wait_drained();

        // interval below three drops to zero after the hold
        apply_setting(16'd2, 16'd5);
        push_poll(32'd1000, 1'b1, 1'b0);
        push_poll(32'd1002, 1'b1, 1'b0);
        push_poll(32'd1003, 1'b1, 1'b0);
        push_poll(32'd1006, 1'b1, 1'b0);
        push_poll(32'd1007, 1'b1, 1'b0);
        push_poll(32'd1007, 1'b1, 1'b0);
        push_poll(32'd1010, 1'b0, 1'b1);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: apply_setting(16'd50, 16'd200);
                1: apply_setting(16'hFFFF, 16'hFFFF);
                2: apply_setting(16'd1, 16'd1);
                3: apply_setting(16'd0, 16'd300);
                4: apply_setting(CfgW'($urandom_range(400, 1)), CfgW'($urandom_range(2000, 0)));
                default: apply_setting(16'd2, 16'd1);
            endcase
            gen_touch_runs(255);
            wait_drained();
        end

        $display("%0d polls sent, %0d words checked, %0d press/repeat events fired",
                 polls_sent, reports_seen, fired_events);
        $display("%0d register settings, with stalls on either side and none",
                 settings_used);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
